FILE: hdl/sma_pkg.sv
// sma_pkg: opcodes, error codes, iterative unit request type and defaults
// for the stack machine ALU. No dependencies.
package sma_pkg;

    localparam int DEF_STACK_DEPTH = 128;
    localparam int DEF_DATA_WIDTH  = 32;

    localparam int MODE_W  = 4;
    localparam int IMM_W   = 32;
    localparam int VALUE_W = 32;
    localparam int ERR_W   = 3;
    localparam int DEPTH_W = 8;
    localparam int S_TDATA_W = 40;   // 36 bits of fields, zero padded
    localparam int M_TDATA_W = 48;   // 44 bits of fields, zero padded

    typedef enum logic [MODE_W-1:0] {
        OP_PUSH   = 4'd0,
        OP_PUSHR  = 4'd1,
        OP_PUSHK  = 4'd2,
        OP_POP    = 4'd3,
        OP_PEEK   = 4'd4,
        OP_KEEP   = 4'd5,
        OP_ADD    = 4'd6,
        OP_SUB    = 4'd7,
        OP_MULT   = 4'd8,
        OP_DIV    = 4'd9,
        OP_SQRT   = 4'd10,
        OP_NOT    = 4'd11,
        OP_OR     = 4'd12,
        OP_AND    = 4'd13,
        OP_MIRROR = 4'd14,
        OP_CLEAR  = 4'd15
    } mode_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 3'd0,
        ERR_FULL  = 3'd1,
        ERR_EMPTY = 3'd2,
        ERR_DIV0  = 3'd3,
        ERR_NEG   = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        IT_MUL  = 2'd0,
        IT_DIV  = 2'd1,
        IT_SQRT = 2'd2
    } iter_op_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
    } iter_req_t;

endpackage

FILE: hdl/stack_machine_alu.sv
// stack_machine_alu: top level. Stack memory, sequencer and side registers.
// Depends on sma_pkg and sma_iter.
//
// Usage:
//   Input channel s_*: one beat is one decoded instruction; s_tdata holds
//   mode in [3:0] and immediate in [35:4]. Result channel m_*: exactly one
//   beat per instruction, in order; m_tdata holds value [31:0], value_valid
//   [32], error [35:33], depth [43:36].
//   One instruction at a time. The accept cycle issues the registered stack
//   read, then an execute cycle, then a finish cycle that writes the stack
//   back and loads the output register. MULT, DIV and SQRT, unless they
//   fail, wait between execute and finish for the result of the shared
//   iterative unit.
//   The output register parts the channels: the next instruction is taken
//   while a result waits; a stalled receiver holds the block in its finish
//   cycle until the output register frees. No state changes until then.
//   Reset (aresetn low, synchronous) empties the stack and zeroes the
//   result and kept registers; stack memory is not cleared, entries are
//   only read below the current depth.
module stack_machine_alu #(
    parameter int STACK_DEPTH = sma_pkg::DEF_STACK_DEPTH,
    parameter int DATA_WIDTH  = sma_pkg::DEF_DATA_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sma_pkg::S_TDATA_W-1:0] s_tdata,   // mode, immediate
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sma_pkg::M_TDATA_W-1:0] m_tdata    // value, value_valid, error, depth
);
    localparam int DW = DATA_WIDTH;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [DW-1:0] mem [STACK_DEPTH];

    logic [CW-1:0]     count_reg;
    logic [DW-1:0]     result_reg, kept_reg;
    sma_pkg::mode_t    mode_reg;
    logic [DW-1:0]     imm_reg;
    logic [DW-1:0]     rd_top_reg, rd_sec_reg;

    // finish-cycle payload, settled in EXEC/WAIT
    logic [DW-1:0]     val_reg, val_next;
    logic              vld_reg, vld_next;
    sma_pkg::err_t     err_reg, err_next;
    logic              we_reg, we_next;
    logic [AW-1:0]     wa_reg, wa_next;
    logic [CW-1:0]     cnt_upd_reg, cnt_upd_next;
    logic              res_we_reg, res_we_next;
    logic              kept_we_reg, kept_we_next;

    logic                   m_tvalid_reg;
    logic [sma_pkg::M_TDATA_W-1:0] m_tdata_reg;

    sma_pkg::iter_req_t     iter_req;
    logic                   iter_done;
    logic [DW-1:0]          iter_result;

    logic          acc_in, fin_go;
    logic [AW-1:0] ra_top, ra_sec;
    logic [DW-1:0] mirror_v;

    assign s_tready = (state_reg == ST_IDLE);
    assign acc_in   = s_tvalid && s_tready;
    assign fin_go   = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);
    assign ra_top   = AW'(count_reg - 1'b1);
    assign ra_sec   = AW'(count_reg - 2'd2);

    always_comb begin
        for (int i = 0; i < DW; i++) mirror_v[i] = rd_top_reg[DW-1-i];
    end

    sma_iter #(.DATA_WIDTH(DATA_WIDTH)) u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (iter_req),
        .a       (rd_top_reg),
        .b       (rd_sec_reg),
        .done    (iter_done),
        .result  (iter_result)
    );

    // stack memory: two registered reads at accept, one write at finish
    always_ff @(posedge aclk) begin
        if (acc_in) begin
            rd_top_reg <= mem[ra_top];
            rd_sec_reg <= mem[ra_sec];
        end
        if (fin_go && we_reg) mem[wa_reg] <= val_reg;
    end

    // execute decode
    always_comb begin
        state_next   = state_reg;
        val_next     = val_reg;
        vld_next     = vld_reg;
        err_next     = err_reg;
        we_next      = we_reg;
        wa_next      = wa_reg;
        cnt_upd_next = cnt_upd_reg;
        res_we_next  = res_we_reg;
        kept_we_next = kept_we_reg;
        iter_req.start = 1'b0;
        iter_req.op    = sma_pkg::IT_MUL;

        unique case (state_reg)
            ST_IDLE: begin
                if (acc_in) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                val_next     = '0;
                vld_next     = 1'b0;
                err_next     = sma_pkg::ERR_NONE;
                we_next      = 1'b0;
                wa_next      = ra_top;
                cnt_upd_next = count_reg;
                res_we_next  = 1'b0;
                kept_we_next = 1'b0;
                state_next   = ST_FIN;
                case (mode_reg)
                    sma_pkg::OP_PUSH, sma_pkg::OP_PUSHR, sma_pkg::OP_PUSHK: begin
                        if (count_reg >= CW'(STACK_DEPTH)) begin
                            err_next = sma_pkg::ERR_FULL;
                        end else begin
                            we_next      = 1'b1;
                            wa_next      = AW'(count_reg);
                            cnt_upd_next = count_reg + 1'b1;
                            val_next     = (mode_reg == sma_pkg::OP_PUSH) ? imm_reg :
                                           (mode_reg == sma_pkg::OP_PUSHR) ? result_reg
                                                                           : kept_reg;
                        end
                    end
                    sma_pkg::OP_POP, sma_pkg::OP_PEEK, sma_pkg::OP_KEEP: begin
                        if (count_reg == '0) begin
                            err_next = sma_pkg::ERR_EMPTY;
                        end else begin
                            val_next = rd_top_reg;
                            vld_next = 1'b1;
                            if (mode_reg == sma_pkg::OP_POP) cnt_upd_next = count_reg - 1'b1;
                            kept_we_next = (mode_reg == sma_pkg::OP_KEEP);
                        end
                    end
                    sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_MULT,
                    sma_pkg::OP_DIV, sma_pkg::OP_OR, sma_pkg::OP_AND: begin
                        if (count_reg < CW'(2)) begin
                            err_next = sma_pkg::ERR_EMPTY;
                        end else if (mode_reg == sma_pkg::OP_DIV && rd_sec_reg == '0) begin
                            err_next = sma_pkg::ERR_DIV0;
                        end else begin
                            we_next      = 1'b1;
                            wa_next      = ra_sec;
                            cnt_upd_next = count_reg - 1'b1;
                            res_we_next  = 1'b1;
                            vld_next     = 1'b1;
                            case (mode_reg)
                                sma_pkg::OP_ADD: val_next = rd_top_reg + rd_sec_reg;
                                sma_pkg::OP_SUB: val_next = rd_top_reg - rd_sec_reg;
                                sma_pkg::OP_OR:  val_next = rd_top_reg | rd_sec_reg;
                                sma_pkg::OP_AND: val_next = rd_top_reg & rd_sec_reg;
                                default: begin
                                    iter_req.start = 1'b1;
                                    iter_req.op = (mode_reg == sma_pkg::OP_DIV) ?
                                                  sma_pkg::IT_DIV : sma_pkg::IT_MUL;
                                    state_next = ST_WAIT;
                                end
                            endcase
                        end
                    end
                    sma_pkg::OP_SQRT, sma_pkg::OP_NOT, sma_pkg::OP_MIRROR: begin
                        if (count_reg == '0) begin
                            err_next = sma_pkg::ERR_EMPTY;
                        end else if (mode_reg == sma_pkg::OP_SQRT && rd_top_reg[DW-1]) begin
                            err_next = sma_pkg::ERR_NEG;
                        end else begin
                            we_next  = 1'b1;
                            vld_next = 1'b1;
                            if (mode_reg == sma_pkg::OP_SQRT) begin
                                iter_req.start = 1'b1;
                                iter_req.op    = sma_pkg::IT_SQRT;
                                state_next     = ST_WAIT;
                            end else begin
                                res_we_next = 1'b1;
                                val_next = (mode_reg == sma_pkg::OP_NOT) ? ~rd_top_reg
                                                                         : mirror_v;
                            end
                        end
                    end
                    default: cnt_upd_next = '0;   // clear
                endcase
            end
            ST_WAIT: begin
                if (iter_done) begin
                    val_next   = iter_result;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (fin_go) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            result_reg   <= '0;
            kept_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fin_go) begin
                count_reg <= cnt_upd_reg;
                if (res_we_reg)  result_reg <= val_reg;
                if (kept_we_reg) kept_reg   <= val_reg;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (acc_in) begin
            mode_reg <= sma_pkg::mode_t'(s_tdata[sma_pkg::MODE_W-1:0]);
            imm_reg  <= DW'($signed(s_tdata[sma_pkg::MODE_W +: sma_pkg::IMM_W]));
        end
        val_reg     <= val_next;
        vld_reg     <= vld_next;
        err_reg     <= err_next;
        we_reg      <= we_next;
        wa_reg      <= wa_next;
        cnt_upd_reg <= cnt_upd_next;
        res_we_reg  <= res_we_next;
        kept_we_reg <= kept_we_next;
        if (fin_go) begin
            m_tdata_reg <= sma_pkg::M_TDATA_W'({
                sma_pkg::DEPTH_W'(cnt_upd_reg),
                err_reg,
                vld_reg,
                vld_reg ? sma_pkg::VALUE_W'($signed(val_reg)) : {sma_pkg::VALUE_W{1'b0}}
            });
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH)) else $error("stack count above depth");
    a_fin_out: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_go |=> m_tvalid) else $error("finished beat not presented");
    a_iter_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_done |-> state_reg == ST_WAIT) else $error("iter done outside wait");
    a_err_novalue: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_go && err_reg != sma_pkg::ERR_NONE) |-> (!vld_reg && !we_reg))
        else $error("error with state change");
`endif

endmodule

FILE: hdl/sma_iter.sv
// sma_iter: shared iterative unit for multiply (shift-add), signed divide
// (restoring, one quotient bit a cycle) and floor square root (two radicand
// bits a cycle). Depends on sma_pkg.
module sma_iter #(
    parameter int DATA_WIDTH = sma_pkg::DEF_DATA_WIDTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sma_pkg::iter_req_t      req,
    input  logic [DATA_WIDTH-1:0]   a,
    input  logic [DATA_WIDTH-1:0]   b,
    output logic                    done,
    output logic [DATA_WIDTH-1:0]   result
);
    localparam int DW   = DATA_WIDTH;
    localparam int HALF = (DW + 1) / 2;
    localparam int EW   = 2 * HALF;
    localparam int RW   = HALF + 2;
    localparam int CNTW = $clog2(DW + 1);

    logic [CNTW-1:0]      cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    sma_pkg::iter_op_t    op_reg;
    logic                 neg_reg;
    logic [DW-1:0]        acc_reg;   // product / remainder
    logic [DW-1:0]        opa_reg;   // multiplicand / dividend-quotient
    logic [DW-1:0]        opb_reg;   // multiplier / divisor
    logic [EW-1:0]        rad_reg;
    logic [RW-1:0]        rem_reg;
    logic [HALF-1:0]      root_reg;

    logic [DW-1:0]        ua, ub;
    logic [DW:0]          dtmp;
    logic [RW+1:0]        rtmp, rtrial;

    assign ua = a[DW-1] ? DW'(-a) : a;
    assign ub = b[DW-1] ? DW'(-b) : b;
    assign dtmp   = {acc_reg, opa_reg[DW-1]};
    assign rtmp   = {rem_reg, rad_reg[EW-1:EW-2]};
    assign rtrial = (RW+2)'({root_reg, 2'b01});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= (req.op == sma_pkg::IT_SQRT) ? CNTW'(HALF) : CNTW'(DW);
                neg_reg  <= a[DW-1] ^ b[DW-1];
                rad_reg  <= EW'(a);
                rem_reg  <= '0;
                root_reg <= '0;
                if (req.op == sma_pkg::IT_DIV) begin
                    acc_reg <= '0;
                    opa_reg <= ua;
                    opb_reg <= ub;
                end else begin
                    acc_reg <= '0;
                    opa_reg <= a;
                    opb_reg <= b;
                end
            end else if (busy_reg) begin
                unique case (op_reg)
                    sma_pkg::IT_MUL: begin
                        if (opb_reg[0]) acc_reg <= acc_reg + opa_reg;
                        opa_reg <= {opa_reg[DW-2:0], 1'b0};
                        opb_reg <= {1'b0, opb_reg[DW-1:1]};
                    end
                    sma_pkg::IT_DIV: begin
                        if (dtmp >= {1'b0, opb_reg}) begin
                            acc_reg <= DW'(dtmp - {1'b0, opb_reg});
                            opa_reg <= {opa_reg[DW-2:0], 1'b1};
                        end else begin
                            acc_reg <= dtmp[DW-1:0];
                            opa_reg <= {opa_reg[DW-2:0], 1'b0};
                        end
                    end
                    default: begin
                        rad_reg <= {rad_reg[EW-3:0], 2'b00};
                        if (rtmp >= rtrial) begin
                            rem_reg  <= RW'(rtmp - rtrial);
                            root_reg <= {root_reg[HALF-2:0], 1'b1};
                        end else begin
                            rem_reg  <= RW'(rtmp);
                            root_reg <= {root_reg[HALF-2:0], 1'b0};
                        end
                    end
                endcase
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        case (op_reg)
            sma_pkg::IT_MUL:  result = acc_reg;
            sma_pkg::IT_DIV:  result = neg_reg ? DW'(-opa_reg) : opa_reg;
            default:          result = DW'(root_reg);
        endcase
    end

    assign done = done_reg;

`ifndef SYNTH
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !req.start) else $error("iter unit restarted while busy");
    a_done_end: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("iter done while still busy");
    a_done_once: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("iter done held two cycles");
`endif

endmodule
